// File: sv/mrrp_pkg.sv
// ----------------------------------------------------------------------------
// mrrp_pkg
// Types, constants and the CRC-16 byte update shared by the request parser.
// ----------------------------------------------------------------------------
package mrrp_pkg;

  localparam logic [7:0]  FUNC_READ_HOLDING = 8'h03;
  localparam logic [15:0] CRC_POLY          = 16'hA001;
  localparam logic [15:0] CRC_INIT          = 16'hFFFF;
  localparam logic [7:0]  SLAVE_ADDR_RESET  = 8'h01;

  localparam logic [7:0]  ADDR_HI_A  = 8'h01;
  localparam logic [7:0]  ADDR_HI_B  = 8'h0B;
  localparam logic [7:0]  ADDR_LO_0  = 8'h00;
  localparam logic [7:0]  ADDR_LO_2  = 8'h02;
  localparam logic [7:0]  ADDR_LO_4  = 8'h04;
  localparam logic [7:0]  ADDR_LO_6  = 8'h06;
  localparam logic [7:0]  QTY_HI     = 8'h00;
  localparam logic [7:0]  QTY_LO_2   = 8'h02;
  localparam logic [7:0]  QTY_LO_4   = 8'h04;

  typedef enum logic [0:0] {
    CMD_BYTE       = 1'b0,
    CMD_TURNAROUND = 1'b1
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE    = 4'd0,
    ST_FUNC    = 4'd1,
    ST_ADDR_HI = 4'd2,
    ST_ADDR_LO = 4'd3,
    ST_QTY_HI  = 4'd4,
    ST_QTY_LO  = 4'd5,
    ST_CRC_LO  = 4'd6,
    ST_CRC_HI  = 4'd7,
    ST_DONE    = 4'd8
  } stage_t;

  typedef struct packed {
    logic       command;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic        frame_valid;
    logic        answer_cancel;
    logic [15:0] register_address;
    logic [3:0]  parser_stage;
  } out_item_t;

  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// File: sv/mrrp_in_reg.sv
// ----------------------------------------------------------------------------
// mrrp_in_reg
// Input register: holds one received beat until the parser core takes it.
// ----------------------------------------------------------------------------
module mrrp_in_reg import mrrp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  output logic     item_valid,
  input  logic     item_ready,
  output in_item_t item
);

  logic     valid_r, valid_nxt;
  in_item_t item_r;
  logic     load;

  assign in_ready   = !valid_r || item_ready;
  assign load       = in_valid && in_ready;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_comb begin
    if (load) begin
      valid_nxt = 1'b1;
    end else if (item_ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_data;
    end
  end

endmodule

// File: sv/mrrp_core.sv
// ----------------------------------------------------------------------------
// mrrp_core
// Frame state machine, CRC accumulation and the result register.
// ----------------------------------------------------------------------------
module mrrp_core import mrrp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  logic [7:0] cfg_wdata,
  input  logic      item_valid,
  output logic      item_ready,
  input  in_item_t  item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  stage_t      stage_r, stage_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [15:0] held_r, held_nxt;
  logic [7:0]  crc_lo_r, crc_lo_nxt;
  logic [7:0]  slave_r;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_r;
  logic        advance;
  logic        frame_ok, cancel;
  logic [15:0] crc_step;
  logic [7:0]  b;
  logic        is_byte;

  assign item_ready = !out_valid_r || out_ready;
  assign advance    = item_valid && item_ready;
  assign b          = item.rx_byte;
  assign is_byte    = (cmd_t'(item.command) == CMD_BYTE);
  assign crc_step   = crc_fold((stage_r == ST_IDLE) ? CRC_INIT : crc_r, b);
  assign out_valid  = out_valid_r;
  assign out_data   = out_r;

  // next state
  always_comb begin
    stage_nxt = ST_IDLE;
    if (is_byte) begin
      unique case (stage_r)
        ST_FUNC:    stage_nxt = (b == FUNC_READ_HOLDING) ? ST_ADDR_HI : ST_IDLE;
        ST_ADDR_HI: stage_nxt = (b == ADDR_HI_A || b == ADDR_HI_B) ? ST_ADDR_LO : ST_IDLE;
        ST_ADDR_LO: stage_nxt = (b == ADDR_LO_0 || b == ADDR_LO_2 || b == ADDR_LO_4 ||
                                 b == ADDR_LO_6) ? ST_QTY_HI : ST_IDLE;
        ST_QTY_HI:  stage_nxt = (b == QTY_HI) ? ST_QTY_LO : ST_IDLE;
        ST_QTY_LO:  stage_nxt = (b == QTY_LO_2 || b == QTY_LO_4) ? ST_CRC_LO : ST_IDLE;
        ST_CRC_LO:  stage_nxt = ST_CRC_HI;
        ST_CRC_HI:  stage_nxt = (crc_lo_r == crc_r[7:0] && b == crc_r[15:8]) ?
                                ST_DONE : ST_IDLE;
        ST_DONE:    stage_nxt = ST_IDLE;
        default:    stage_nxt = (b == slave_r) ? ST_FUNC : ST_IDLE;
      endcase
    end
  end

  // datapath and flags
  always_comb begin
    crc_nxt    = crc_r;
    held_nxt   = held_r;
    crc_lo_nxt = crc_lo_r;
    frame_ok   = 1'b0;
    cancel     = 1'b0;
    if (is_byte) begin
      unique case (stage_r)
        ST_FUNC, ST_QTY_HI, ST_QTY_LO: begin
          if (stage_nxt != ST_IDLE) crc_nxt = crc_step;
        end
        ST_ADDR_HI: begin
          if (stage_nxt != ST_IDLE) begin
            crc_nxt  = crc_step;
            held_nxt = held_r | {b, 8'h00};
          end
        end
        ST_ADDR_LO: begin
          if (stage_nxt != ST_IDLE) begin
            crc_nxt  = crc_step;
            held_nxt = held_r | {8'h00, b};
          end else begin
            held_nxt = '0;
          end
        end
        ST_CRC_LO: crc_lo_nxt = b;
        ST_CRC_HI: frame_ok = (stage_nxt == ST_DONE);
        ST_DONE:   cancel = 1'b1;
        default: begin
          if (stage_nxt == ST_FUNC) begin
            held_nxt = '0;
            crc_nxt  = crc_step;
          end
        end
      endcase
    end
  end

  always_comb begin
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r     <= ST_IDLE;
      crc_r       <= CRC_INIT;
      held_r      <= '0;
      crc_lo_r    <= '0;
      slave_r     <= SLAVE_ADDR_RESET;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        slave_r <= cfg_wdata;
      end
      if (advance) begin
        stage_r  <= stage_nxt;
        crc_r    <= crc_nxt;
        held_r   <= held_nxt;
        crc_lo_r <= crc_lo_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r.frame_valid      <= frame_ok;
      out_r.answer_cancel    <= cancel;
      out_r.register_address <= held_nxt;
      out_r.parser_stage     <= stage_nxt;
    end
  end

endmodule

// File: sv/modbus_read_request_parser.sv
// ----------------------------------------------------------------------------
// modbus_read_request_parser
// Byte-wise parser for a read-holding-registers request with CRC-16 check.
//
//   port group | dir | beat contents
//   in_        | in  | command, rx_byte
//   out_       | out | frame_valid, answer_cancel, register_address,
//              |     | parser_stage
//   cfg_       | in  | slave_address (write only)
//
// One beat per cycle while out_ready stays high; each beat passes the
// input register, then the result register. The stage transition and
// byte-wide CRC update sit between the input register and the result
// register. Synchronous reset clears the parser to idle, CRC to 0xFFFF
// and slave address to 1. A stalled result holds the input register;
// the in_ side keeps taking beats while either register has room.
// ----------------------------------------------------------------------------
module modbus_read_request_parser import mrrp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);

  logic     item_valid;
  logic     item_ready;
  in_item_t item;

  mrrp_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item)
  );

  mrrp_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the read-holding-registers request parser.
//
// Byte and turnaround beats are queued by the stimulus process, which writes
// the slave address between phases while the parser is drained. The driver
// puts them on in_ and the monitor takes results from out_. Both sides stall
// at random outside the steady phase. Each accepted input beat runs through
// a local model of the parser: stage walk, CRC-16 accumulation and held
// address. Each result is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb import mrrp_pkg::*; ();

  localparam int STALL_LIMIT = 2000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;
  logic      cfg_we;
  logic [7:0] cfg_wdata;

  in_item_t  rx_pending[$];
  out_item_t parse_expected[$];

  // model state
  logic [7:0]  slave_cfg;
  stage_t      mdl_stage;
  logic [15:0] mdl_crc;
  logic [15:0] mdl_addr;
  logic [7:0]  mdl_crc_lo;

  logic steady;
  int   fails;
  int   out_cnt;
  int   stall_cnt;

  modbus_read_request_parser i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [15:0] crc16_byte(input logic [15:0] acc, input logic [7:0] d);
    logic [15:0] r;
    r = acc ^ {8'h00, d};
    repeat (8) begin
      r = r[0] ? ({1'b0, r[15:1]} ^ CRC_POLY) : {1'b0, r[15:1]};
    end
    return r;
  endfunction

  function automatic out_item_t parse_step(input in_item_t beat);
    out_item_t  r;
    logic       hit;
    logic       cancel;
    logic [7:0] b;
    hit    = 1'b0;
    cancel = 1'b0;
    b      = beat.rx_byte;
    if (beat.command == CMD_TURNAROUND) begin
      mdl_stage = ST_IDLE;
    end else begin
      case (mdl_stage)
        ST_FUNC: begin
          if (b == FUNC_READ_HOLDING) begin
            mdl_crc   = crc16_byte(mdl_crc, b);
            mdl_stage = ST_ADDR_HI;
          end else begin
            mdl_stage = ST_IDLE;
          end
        end
        ST_ADDR_HI: begin
          if (b == ADDR_HI_A || b == ADDR_HI_B) begin
            mdl_addr  = mdl_addr | {b, 8'h00};
            mdl_crc   = crc16_byte(mdl_crc, b);
            mdl_stage = ST_ADDR_LO;
          end else begin
            mdl_stage = ST_IDLE;
          end
        end
        ST_ADDR_LO: begin
          if (b == ADDR_LO_0 || b == ADDR_LO_2 || b == ADDR_LO_4 || b == ADDR_LO_6) begin
            mdl_addr  = mdl_addr | {8'h00, b};
            mdl_crc   = crc16_byte(mdl_crc, b);
            mdl_stage = ST_QTY_HI;
          end else begin
            mdl_stage = ST_IDLE;
            mdl_addr  = 16'h0000;
          end
        end
        ST_QTY_HI: begin
          if (b == QTY_HI) begin
            mdl_crc   = crc16_byte(mdl_crc, b);
            mdl_stage = ST_QTY_LO;
          end else begin
            mdl_stage = ST_IDLE;
          end
        end
        ST_QTY_LO: begin
          if (b == QTY_LO_2 || b == QTY_LO_4) begin
            mdl_crc   = crc16_byte(mdl_crc, b);
            mdl_stage = ST_CRC_LO;
          end else begin
            mdl_stage = ST_IDLE;
          end
        end
        ST_CRC_LO: begin
          mdl_crc_lo = b;
          mdl_stage  = ST_CRC_HI;
        end
        ST_CRC_HI: begin
          if (mdl_crc_lo == mdl_crc[7:0] && b == mdl_crc[15:8]) begin
            hit       = 1'b1;
            mdl_stage = ST_DONE;
          end else begin
            mdl_stage = ST_IDLE;
          end
        end
        ST_DONE: begin
          cancel    = 1'b1;
          mdl_stage = ST_IDLE;
        end
        default: begin
          mdl_stage = ST_IDLE;
          if (b == slave_cfg) begin
            mdl_addr  = 16'h0000;
            mdl_crc   = crc16_byte(CRC_INIT, b);
            mdl_stage = ST_FUNC;
          end
        end
      endcase
    end
    r.frame_valid      = hit;
    r.answer_cancel    = cancel;
    r.register_address = mdl_addr;
    r.parser_stage     = mdl_stage;
    return r;
  endfunction

  function automatic logic idle_roll();
    return !steady && ($urandom_range(0, 99) < 26);
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        parse_expected.push_back(parse_step(in_data));
      end
      if (!in_valid || in_ready) begin
        if (rx_pending.size() != 0 && !idle_roll()) begin
          in_valid <= 1'b1;
          in_data  <= rx_pending.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    out_item_t exp_r;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (parse_expected.size() == 0) begin
          fails++;
          if (fails <= 10) begin
            $display("beat %0d: unexpected result %h", out_cnt, out_data);
          end
        end else begin
          exp_r = parse_expected.pop_front();
          if (out_data.frame_valid !== exp_r.frame_valid ||
              out_data.answer_cancel !== exp_r.answer_cancel ||
              out_data.register_address !== exp_r.register_address ||
              out_data.parser_stage !== exp_r.parser_stage) begin
            fails++;
            if (fails <= 10) begin
              $display("beat %0d: expected valid=%0b cancel=%0b addr=%h stage=%0d",
                       out_cnt, exp_r.frame_valid, exp_r.answer_cancel,
                       exp_r.register_address, exp_r.parser_stage);
              $display("beat %0d: got      valid=%0b cancel=%0b addr=%h stage=%0d",
                       out_cnt, out_data.frame_valid, out_data.answer_cancel,
                       out_data.register_address, out_data.parser_stage);
            end
          end
        end
        out_cnt++;
      end
      out_ready <= !idle_roll();
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt == STALL_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  function automatic void push_beat(input logic cmd, input logic [7:0] b);
    in_item_t t;
    t.command = cmd;
    t.rx_byte = b;
    rx_pending.push_back(t);
  endfunction

  // Queues the first len bytes of a request, byte bad_pos xored with bad_mask.
  function automatic int push_frame(input logic [7:0] hi, input logic [7:0] lo,
                                    input logic [7:0] qty, input int bad_pos,
                                    input logic [7:0] bad_mask, input int len);
    logic [7:0]  fb [8];
    logic [15:0] crc;
    fb[0] = slave_cfg;
    fb[1] = FUNC_READ_HOLDING;
    fb[2] = hi;
    fb[3] = lo;
    fb[4] = QTY_HI;
    fb[5] = qty;
    crc = CRC_INIT;
    for (int i = 0; i < 6; i++) crc = crc16_byte(crc, fb[i]);
    fb[6] = crc[7:0];
    fb[7] = crc[15:8];
    if (bad_pos >= 0 && bad_pos < 8) fb[bad_pos] = fb[bad_pos] ^ bad_mask;
    for (int i = 0; i < len; i++) push_beat(CMD_BYTE, fb[i]);
    return len;
  endfunction

  task automatic gen_random(input int n);
    int         made;
    int         pick;
    logic [7:0] hi;
    logic [7:0] lo;
    logic [7:0] qty;
    made = 0;
    while (made < n) begin
      pick = $urandom_range(0, 99);
      hi   = $urandom_range(0, 1) ? ADDR_HI_B : ADDR_HI_A;
      lo   = 8'(2 * $urandom_range(0, 3));
      qty  = $urandom_range(0, 1) ? QTY_LO_4 : QTY_LO_2;
      if (pick < 55) begin
        made += push_frame(hi, lo, qty, -1, 8'h00, 8);
        case ($urandom_range(0, 2))
          0: begin
            push_beat(CMD_BYTE, 8'($urandom_range(0, 255)));
            made++;
          end
          1: begin
            push_beat(CMD_TURNAROUND, 8'($urandom_range(0, 255)));
            made++;
          end
          default: ;
        endcase
      end else if (pick < 80) begin
        made += push_frame(hi, lo, qty, $urandom_range(0, 7), 8'($urandom_range(0, 255)), 8);
      end else if (pick < 88) begin
        made += push_frame(hi, lo, qty, -1, 8'h00, $urandom_range(1, 7));
        push_beat(CMD_TURNAROUND, 8'($urandom_range(0, 255)));
        made++;
      end else begin
        repeat ($urandom_range(1, 4)) begin
          push_beat(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
          made++;
        end
      end
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (!(rx_pending.size() == 0 && !in_valid && parse_expected.size() == 0));
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [7:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    slave_cfg  = v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_data    <= '0;
    out_ready  <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_wdata  <= 8'h00;
    steady     <= 1'b0;
    fails      = 0;
    out_cnt    = 0;
    slave_cfg  = SLAVE_ADDR_RESET;
    mdl_stage  = ST_IDLE;
    mdl_crc    = CRC_INIT;
    mdl_addr   = 16'h0000;
    mdl_crc_lo = 8'h00;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed, reset slave address
    void'(push_frame(ADDR_HI_A, ADDR_LO_0, QTY_LO_2, -1, 8'h00, 8));
    push_beat(CMD_BYTE, 8'hFF);                 // cancels the answer
    push_beat(CMD_BYTE, 8'h00);                 // not our address, ignored
    void'(push_frame(ADDR_HI_B, ADDR_LO_6, QTY_LO_4, 7, 8'hFF, 8));   // bad CRC
    push_beat(CMD_TURNAROUND, 8'hFF);
    void'(push_frame(ADDR_HI_B, ADDR_LO_6, QTY_LO_4, 3, 8'h03, 4));   // bad address low
    wait_drained();

    cfg_write(8'd247);
    gen_random(150);
    wait_drained();

    cfg_write(8'($urandom_range(2, 246)));
    steady <= 1'b1;
    gen_random(150);
    wait_drained();
    steady <= 1'b0;

    cfg_write(8'd1);
    gen_random(150);
    wait_drained();

    cfg_write(8'($urandom_range(2, 246)));
    gen_random(150);
    wait_drained();
    repeat (4) @(posedge clk);

    if (fails == 0 && parse_expected.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: modbus_read_request_parser.f
sv/mrrp_pkg.sv
sv/mrrp_in_reg.sv
sv/mrrp_core.sv
sv/modbus_read_request_parser.sv
sim/tb.sv
